// ----- hdl/hsv_pkg.sv -----
// Shared constants, pixel types and sector helpers for the HSV to RGB converter.
`timescale 1ns / 1ps

package hsv_pkg;

    localparam int CHANNEL_BITS = 8;
    localparam int HUE_BITS     = 17;
    localparam int FRAC_BITS    = 8;
    localparam int SEC_BITS     = 3;

    localparam logic [HUE_BITS-1:0] HUE_MAX     = HUE_BITS'(92159);
    localparam int                  SECTOR_SPAN = 60 << FRAC_BITS;
    localparam int                  REM_BITS    = $clog2(SECTOR_SPAN);

    // floor(x / 15) = (x * FRAC_RECIP) >> RECIP_SHIFT for x < 4993
    localparam int                    RECIP_BITS  = 17;
    localparam logic [RECIP_BITS-1:0] FRAC_RECIP  = RECIP_BITS'(69906);
    localparam int                    RECIP_SHIFT = 20;

    localparam logic [SEC_BITS-1:0] SEC_RY = 3'd0;
    localparam logic [SEC_BITS-1:0] SEC_YG = 3'd1;
    localparam logic [SEC_BITS-1:0] SEC_GC = 3'd2;
    localparam logic [SEC_BITS-1:0] SEC_CB = 3'd3;
    localparam logic [SEC_BITS-1:0] SEC_BM = 3'd4;
    localparam logic [SEC_BITS-1:0] SEC_MR = 3'd5;

    typedef struct packed {
        logic [HUE_BITS-1:0]     hue_angle;
        logic [CHANNEL_BITS-1:0] sat_level;
        logic [CHANNEL_BITS-1:0] bright_level;
    } hsv_pixel_t;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red_out;
        logic [CHANNEL_BITS-1:0] green_out;
        logic [CHANNEL_BITS-1:0] blue_out;
    } rgb_pixel_t;

    function automatic logic [HUE_BITS-1:0] sector_base(input logic [SEC_BITS-1:0] sec);
        logic [HUE_BITS-1:0] base;
        case (sec)
            SEC_RY:  base = HUE_BITS'(0);
            SEC_YG:  base = HUE_BITS'(SECTOR_SPAN);
            SEC_GC:  base = HUE_BITS'(2 * SECTOR_SPAN);
            SEC_CB:  base = HUE_BITS'(3 * SECTOR_SPAN);
            SEC_BM:  base = HUE_BITS'(4 * SECTOR_SPAN);
            SEC_MR:  base = HUE_BITS'(5 * SECTOR_SPAN);
            default: base = HUE_BITS'(0);
        endcase
        return base;
    endfunction

endpackage

// ----- hdl/hsv_rdiv.sv -----
// Division by 2^CW - 1 for dividends below (2^CW - 1) * 2^CW, with remainder correction.
`timescale 1ns / 1ps

module hsv_rdiv #(
    parameter int CW = hsv_pkg::CHANNEL_BITS
) (
    input  logic [2*CW-1:0] dividend,
    output logic [CW-1:0]   quotient
);

    localparam logic [CW:0] DIV_M  = {1'b0, {CW{1'b1}}};
    localparam logic [CW:0] DIV_M2 = {{CW{1'b1}}, 1'b0};

    logic [CW-1:0] quo_est;
    logic [CW:0]   rem_est;
    logic [CW:0]   quo_fix;

    assign quo_est = dividend[2*CW-1:CW];
    assign rem_est = {1'b0, dividend[CW-1:0]} + {1'b0, quo_est};

    always_comb
    begin
        if (rem_est >= DIV_M2)
        begin
            quo_fix = {1'b0, quo_est} + (CW+1)'(2);
        end
        else if (rem_est >= DIV_M)
        begin
            quo_fix = {1'b0, quo_est} + (CW+1)'(1);
        end
        else
        begin
            quo_fix = {1'b0, quo_est};
        end
    end

    assign quotient = quo_fix[CW-1:0];

endmodule

// ----- hdl/hsv_to_rgb_converter_top.sv -----
// Top level of the HSV to RGB pixel converter: seven-stage stallable pipeline.
`timescale 1ns / 1ps

// Converts one HSV pixel to one RGB pixel per clock unless rgb_stall holds it. Every pixel
// passes seven register stages (clamp and sector, in-sector remainder, fraction and p
// product, s*f terms, q/t products, rounding offsets, divide by channel max and routing).
// Each stage has its own valid bit and advances when the stage ahead is empty or moving,
// so empty stages fill up behind a stalled output; hsv_stall rises only once all seven
// stages hold pixels and rgb_stall is high.
module hsv_to_rgb_converter_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                hsv_valid,
    output logic                hsv_stall,
    input  hsv_pkg::hsv_pixel_t hsv_data,
    output logic                rgb_valid,
    input  logic                rgb_stall,
    output hsv_pkg::rgb_pixel_t rgb_data
);

    localparam int C    = hsv_pkg::CHANNEL_BITS;
    localparam int FB   = hsv_pkg::FRAC_BITS;
    localparam int HB   = hsv_pkg::HUE_BITS;
    localparam int SB   = hsv_pkg::SEC_BITS;
    localparam int RB   = hsv_pkg::REM_BITS;
    localparam int DW   = C + FB;
    localparam int NW   = 2 * C + FB;
    localparam int PW   = RB - 2 + hsv_pkg::RECIP_BITS;
    localparam int NST  = 7;

    localparam logic [C-1:0]  CH_MAX   = {C{1'b1}};
    localparam logic [DW-1:0] DEN      = {CH_MAX, {FB{1'b0}}};
    localparam logic [NW-1:0] HALF_DEN = NW'({CH_MAX, {(FB-1){1'b0}}});
    localparam logic [2*C-1:0] HALF_M  = (2*C)'(CH_MAX >> 1);

    logic [NST:1] vld_reg;
    logic [NST:1] vld_next;
    logic [NST:1] en;

    // stage 1
    logic [HB-1:0] hue_cl;
    logic [SB-1:0] sec_next;
    logic [HB-1:0] s1_hue_reg;
    logic [SB-1:0] s1_sec_reg;
    logic [C-1:0]  s1_sat_reg;
    logic [C-1:0]  s1_val_reg;
    // stage 2
    logic [HB-1:0] rem_full;
    logic [RB-1:0] rem_next;
    logic [RB-1:0] s2_rem_reg;
    logic [SB-1:0] s2_sec_reg;
    logic [C-1:0]  s2_sat_reg;
    logic [C-1:0]  s2_val_reg;
    // stage 3
    logic [PW-1:0]  fprod;
    logic [FB-1:0]  frac_next;
    logic [2*C-1:0] pprod_next;
    logic [FB-1:0]  s3_frac_reg;
    logic [2*C-1:0] s3_pprod_reg;
    logic [SB-1:0]  s3_sec_reg;
    logic [C-1:0]   s3_sat_reg;
    logic [C-1:0]   s3_val_reg;
    // stage 4
    logic [FB:0]    frac_cmp;
    logic [DW-1:0]  sf_prod;
    logic [DW-1:0]  sg_prod;
    logic [DW-1:0]  dq_next;
    logic [DW-1:0]  dt_next;
    logic [2*C-1:0] ap_next;
    logic [DW-1:0]  s4_dq_reg;
    logic [DW-1:0]  s4_dt_reg;
    logic [2*C-1:0] s4_ap_reg;
    logic [SB-1:0]  s4_sec_reg;
    logic [C-1:0]   s4_val_reg;
    // stage 5
    logic [NW-1:0]  nq_next;
    logic [NW-1:0]  nt_next;
    logic [NW-1:0]  s5_nq_reg;
    logic [NW-1:0]  s5_nt_reg;
    logic [2*C-1:0] s5_ap_reg;
    logic [SB-1:0]  s5_sec_reg;
    logic [C-1:0]   s5_val_reg;
    // stage 6
    logic [NW-1:0]  aq_sum;
    logic [NW-1:0]  at_sum;
    logic [2*C-1:0] s6_yq_reg;
    logic [2*C-1:0] s6_yt_reg;
    logic [2*C-1:0] s6_yp_reg;
    logic [SB-1:0]  s6_sec_reg;
    logic [C-1:0]   s6_val_reg;
    // stage 7
    logic [C-1:0]        p_val;
    logic [C-1:0]        q_val;
    logic [C-1:0]        t_val;
    hsv_pkg::rgb_pixel_t out_next;
    hsv_pkg::rgb_pixel_t out_reg;

    // stage enables and valid chain
    always_comb
    begin
        en[NST] = !vld_reg[NST] || !rgb_stall;
        for (int k = NST - 1; k >= 1; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        vld_next[1] = en[1] ? hsv_valid : vld_reg[1];
        for (int k = 2; k <= NST; k++)
        begin
            if (en[k])
            begin
                vld_next[k] = vld_reg[k-1];
            end
            else
            begin
                vld_next[k] = vld_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign hsv_stall = !en[1];
    assign rgb_valid = vld_reg[NST];
    assign rgb_data  = out_reg;

    // stage 1: clamp hue, find sector
    always_comb
    begin
        hue_cl = (hsv_data.hue_angle > hsv_pkg::HUE_MAX) ? hsv_pkg::HUE_MAX
                                                          : hsv_data.hue_angle;
        if (hue_cl >= hsv_pkg::sector_base(hsv_pkg::SEC_MR))
        begin
            sec_next = hsv_pkg::SEC_MR;
        end
        else if (hue_cl >= hsv_pkg::sector_base(hsv_pkg::SEC_BM))
        begin
            sec_next = hsv_pkg::SEC_BM;
        end
        else if (hue_cl >= hsv_pkg::sector_base(hsv_pkg::SEC_CB))
        begin
            sec_next = hsv_pkg::SEC_CB;
        end
        else if (hue_cl >= hsv_pkg::sector_base(hsv_pkg::SEC_GC))
        begin
            sec_next = hsv_pkg::SEC_GC;
        end
        else if (hue_cl >= hsv_pkg::sector_base(hsv_pkg::SEC_YG))
        begin
            sec_next = hsv_pkg::SEC_YG;
        end
        else
        begin
            sec_next = hsv_pkg::SEC_RY;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_hue_reg <= hue_cl;
            s1_sec_reg <= sec_next;
            s1_sat_reg <= hsv_data.sat_level;
            s1_val_reg <= hsv_data.bright_level;
        end
    end

    // stage 2: remainder inside sector
    assign rem_full = s1_hue_reg - hsv_pkg::sector_base(s1_sec_reg);
    assign rem_next = rem_full[RB-1:0];

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s2_rem_reg <= rem_next;
            s2_sec_reg <= s1_sec_reg;
            s2_sat_reg <= s1_sat_reg;
            s2_val_reg <= s1_val_reg;
        end
    end

    // stage 3: f = floor(rem / 60), p numerator
    assign fprod      = PW'(s2_rem_reg[RB-1:2]) * PW'(hsv_pkg::FRAC_RECIP);
    assign frac_next  = fprod[hsv_pkg::RECIP_SHIFT+FB-1:hsv_pkg::RECIP_SHIFT];
    assign pprod_next = (2*C)'(s2_val_reg) * (2*C)'(CH_MAX - s2_sat_reg);

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s3_frac_reg  <= frac_next;
            s3_pprod_reg <= pprod_next;
            s3_sec_reg   <= s2_sec_reg;
            s3_sat_reg   <= s2_sat_reg;
            s3_val_reg   <= s2_val_reg;
        end
    end

    // stage 4: 256M - s*f, 256M - s*(1-f), p rounding offset
    assign frac_cmp = (FB+1)'(1 << FB) - {1'b0, s3_frac_reg};
    assign sf_prod  = DW'(s3_sat_reg) * DW'(s3_frac_reg);
    assign sg_prod  = DW'(s3_sat_reg) * DW'(frac_cmp);
    assign dq_next  = DEN - sf_prod;
    assign dt_next  = DEN - sg_prod;
    assign ap_next  = s3_pprod_reg + HALF_M;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s4_dq_reg  <= dq_next;
            s4_dt_reg  <= dt_next;
            s4_ap_reg  <= ap_next;
            s4_sec_reg <= s3_sec_reg;
            s4_val_reg <= s3_val_reg;
        end
    end

    // stage 5: q and t numerators
    assign nq_next = NW'(s4_val_reg) * NW'(s4_dq_reg);
    assign nt_next = NW'(s4_val_reg) * NW'(s4_dt_reg);

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s5_nq_reg  <= nq_next;
            s5_nt_reg  <= nt_next;
            s5_ap_reg  <= s4_ap_reg;
            s5_sec_reg <= s4_sec_reg;
            s5_val_reg <= s4_val_reg;
        end
    end

    // stage 6: add half denominator, drop fraction bits
    assign aq_sum = s5_nq_reg + HALF_DEN;
    assign at_sum = s5_nt_reg + HALF_DEN;

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            s6_yq_reg  <= aq_sum[NW-1:FB];
            s6_yt_reg  <= at_sum[NW-1:FB];
            s6_yp_reg  <= s5_ap_reg;
            s6_sec_reg <= s5_sec_reg;
            s6_val_reg <= s5_val_reg;
        end
    end

    // stage 7: divide by channel max, route by sector
    hsv_rdiv #(.CW(C)) u_div_p (.dividend(s6_yp_reg), .quotient(p_val));
    hsv_rdiv #(.CW(C)) u_div_q (.dividend(s6_yq_reg), .quotient(q_val));
    hsv_rdiv #(.CW(C)) u_div_t (.dividend(s6_yt_reg), .quotient(t_val));

    always_comb
    begin
        case (s6_sec_reg)
            hsv_pkg::SEC_RY:
            begin
                out_next.red_out   = s6_val_reg;
                out_next.green_out = t_val;
                out_next.blue_out  = p_val;
            end
            hsv_pkg::SEC_YG:
            begin
                out_next.red_out   = q_val;
                out_next.green_out = s6_val_reg;
                out_next.blue_out  = p_val;
            end
            hsv_pkg::SEC_GC:
            begin
                out_next.red_out   = p_val;
                out_next.green_out = s6_val_reg;
                out_next.blue_out  = t_val;
            end
            hsv_pkg::SEC_CB:
            begin
                out_next.red_out   = p_val;
                out_next.green_out = q_val;
                out_next.blue_out  = s6_val_reg;
            end
            hsv_pkg::SEC_BM:
            begin
                out_next.red_out   = t_val;
                out_next.green_out = p_val;
                out_next.blue_out  = s6_val_reg;
            end
            default:
            begin
                out_next.red_out   = s6_val_reg;
                out_next.green_out = p_val;
                out_next.blue_out  = q_val;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            out_reg <= out_next;
        end
    end

endmodule

// ----- hdl/hsv_checker.sv -----
// Port-level assertions for the HSV to RGB converter, bound to the top level.
`timescale 1ns / 1ps

module hsv_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                hsv_stall,
    input logic                rgb_valid,
    input logic                rgb_stall,
    input hsv_pkg::rgb_pixel_t rgb_data
);

    // no transaction pending out of reset
    a_rst_quiet: assert property (@(posedge clk) !rst_n |-> !rgb_valid)
        else $error("rgb_valid high during reset");

    // input backs up only when the whole pipe is full and the output is held
    a_stall_full: assert property (@(posedge clk) hsv_stall |-> (rgb_valid && rgb_stall))
        else $error("hsv_stall without a stalled output");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rgb_valid && rgb_stall) |=> (rgb_valid && $stable(rgb_data)))
        else $error("stalled rgb transaction changed");

endmodule

bind hsv_to_rgb_converter_top hsv_checker u_hsv_checker (.*);

// ----- bench/hsv_to_rgb_converter_top_tb.sv -----
// Self-checking testbench for the HSV to RGB converter with random handshake pacing.
`timescale 1ns / 1ps

module hsv_to_rgb_converter_top_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_PIXELS = 1000;

    class rgb_scoreboard;
        hsv_pkg::rgb_pixel_t expected_rgb_q[$];
        int                  errors;

        function new();
            errors = 0;
        endfunction

        function hsv_pkg::rgb_pixel_t predict_rgb(hsv_pkg::hsv_pixel_t px);
            longint unsigned  m;
            longint unsigned  hue;
            longint unsigned  s;
            longint unsigned  v;
            longint unsigned  rem;
            longint unsigned  f;
            longint unsigned  one_f;
            longint unsigned  den;
            longint unsigned  p;
            longint unsigned  q;
            longint unsigned  t;
            logic [hsv_pkg::SEC_BITS-1:0]     sector;
            logic [hsv_pkg::CHANNEL_BITS-1:0] v_ch;
            logic [hsv_pkg::CHANNEL_BITS-1:0] p_ch;
            logic [hsv_pkg::CHANNEL_BITS-1:0] q_ch;
            logic [hsv_pkg::CHANNEL_BITS-1:0] t_ch;
            hsv_pkg::rgb_pixel_t              rgb;
            m     = (64'd1 << hsv_pkg::CHANNEL_BITS) - 1;
            one_f = 64'd1 << hsv_pkg::FRAC_BITS;
            hue   = px.hue_angle;
            s     = px.sat_level;
            v     = px.bright_level;
            v_ch  = px.bright_level;
            if (hue > hsv_pkg::HUE_MAX)
                hue = hsv_pkg::HUE_MAX;
            if (s == 0)
            begin
                rgb = '{v_ch, v_ch, v_ch};
            end
            else
            begin
                sector = hsv_pkg::SEC_BITS'(hue / hsv_pkg::SECTOR_SPAN);
                rem    = hue % hsv_pkg::SECTOR_SPAN;
                f      = (rem << hsv_pkg::FRAC_BITS) / hsv_pkg::SECTOR_SPAN;
                den    = m * one_f;
                p      = (v * (m - s) + m / 2) / m;
                q      = (v * (den - s * f) + den / 2) / den;
                t      = (v * (den - s * (one_f - f)) + den / 2) / den;
                p_ch   = hsv_pkg::CHANNEL_BITS'(p);
                q_ch   = hsv_pkg::CHANNEL_BITS'(q);
                t_ch   = hsv_pkg::CHANNEL_BITS'(t);
                case (sector)
                    hsv_pkg::SEC_RY: rgb = '{v_ch, t_ch, p_ch};
                    hsv_pkg::SEC_YG: rgb = '{q_ch, v_ch, p_ch};
                    hsv_pkg::SEC_GC: rgb = '{p_ch, v_ch, t_ch};
                    hsv_pkg::SEC_CB: rgb = '{p_ch, q_ch, v_ch};
                    hsv_pkg::SEC_BM: rgb = '{t_ch, p_ch, v_ch};
                    default:         rgb = '{v_ch, p_ch, q_ch};
                endcase
            end
            return rgb;
        endfunction

        function void note_hsv(hsv_pkg::hsv_pixel_t px);
            expected_rgb_q.push_back(predict_rgb(px));
        endfunction

        function void check_rgb(hsv_pkg::rgb_pixel_t got);
            hsv_pkg::rgb_pixel_t exp_px;
            if (expected_rgb_q.size() == 0)
            begin
                $display("%0t: unexpected rgb transaction %h", $time, got);
                errors++;
                return;
            end
            exp_px = expected_rgb_q.pop_front();
            if (got.red_out !== exp_px.red_out)
            begin
                $display("%0t: red expected %0d got %0d", $time, exp_px.red_out, got.red_out);
                errors++;
            end
            if (got.green_out !== exp_px.green_out)
            begin
                $display("%0t: green expected %0d got %0d", $time,
                         exp_px.green_out, got.green_out);
                errors++;
            end
            if (got.blue_out !== exp_px.blue_out)
            begin
                $display("%0t: blue expected %0d got %0d", $time, exp_px.blue_out, got.blue_out);
                errors++;
            end
        endfunction

        function int pending();
            return expected_rgb_q.size();
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                hsv_valid;
    logic                hsv_stall;
    hsv_pkg::hsv_pixel_t hsv_data;
    logic                rgb_valid;
    logic                rgb_stall = 1'b0;
    hsv_pkg::rgb_pixel_t rgb_data;

    rgb_scoreboard sb;
    bit            steady = 1'b0;
    int            stall_left = 0;
    int            stall_roll;
    int            cycles = 0;

    hsv_to_rgb_converter_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .hsv_valid (hsv_valid),
        .hsv_stall (hsv_stall),
        .hsv_data  (hsv_data),
        .rgb_valid (rgb_valid),
        .rgb_stall (rgb_stall),
        .rgb_data  (rgb_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            rgb_stall <= 1'b1;
        end
        else if (steady)
            rgb_stall <= 1'b0;
        else
        begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 70)
                rgb_stall <= 1'b0;
            else if (stall_roll < 96)
            begin
                stall_left = $urandom_range(0, 2);
                rgb_stall <= 1'b1;
            end
            else
            begin
                stall_left = $urandom_range(8, 40);
                rgb_stall <= 1'b1;
            end
        end
    end

    // input noted first so a result in the same cycle still finds its expectation
    always @(posedge clk)
    begin
        if (rst_n && sb != null)
        begin
            if (hsv_valid && !hsv_stall)
                sb.note_hsv(hsv_data);
            if (rgb_valid && !rgb_stall)
                sb.check_rgb(rgb_data);
        end
    end

    task automatic send_hsv(input hsv_pkg::hsv_pixel_t px);
        int roll;
        int gap;
        roll = $urandom_range(0, 99);
        if (steady || roll < 65)
            gap = 0;
        else if (roll < 95)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 30);
        if (gap > 0)
        begin
            hsv_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        hsv_valid <= 1'b1;
        hsv_data  <= px;
        do
            @(posedge clk);
        while (hsv_stall);
    endtask

    initial
    begin
        hsv_pkg::hsv_pixel_t directed_px[$];
        hsv_pkg::hsv_pixel_t px;
        int                  roll;

        sb = new();
        rst_n     <= 1'b0;
        hsv_valid <= 1'b0;
        hsv_data  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_px.push_back('{17'd0, 8'd255, 8'd255});
        directed_px.push_back('{17'd0, 8'd0, 8'd0});
        directed_px.push_back('{hsv_pkg::HUE_MAX, 8'd255, 8'd255});
        directed_px.push_back('{17'd92160, 8'd200, 8'd100});
        directed_px.push_back('{17'd131071, 8'd255, 8'd255});
        directed_px.push_back('{17'd131071, 8'd0, 8'd255});
        for (int k = 0; k < 6; k++)
            directed_px.push_back('{hsv_pkg::HUE_BITS'(k * hsv_pkg::SECTOR_SPAN
                                    + hsv_pkg::SECTOR_SPAN / 2), 8'd255, 8'd255});
        directed_px.push_back('{17'd15359, 8'd128, 8'd200});
        directed_px.push_back('{17'd15360, 8'd128, 8'd200});
        directed_px.push_back('{17'd76799, 8'd77, 8'd180});
        directed_px.push_back('{17'h0AAAA, 8'h55, 8'hAA});
        directed_px.push_back('{17'h15555, 8'hAA, 8'h55});
        directed_px.push_back('{17'd30000, 8'd1, 8'd255});
        directed_px.push_back('{17'd50000, 8'd255, 8'd1});
        directed_px.push_back('{17'd60000, 8'd0, 8'd137});
        directed_px.push_back('{17'd70000, 8'd255, 8'd0});
        foreach (directed_px[i])
            send_hsv(directed_px[i]);

        for (int i = 0; i < RANDOM_PIXELS; i++)
        begin
            if (i == RANDOM_PIXELS / 2)
            begin
                hsv_valid <= 1'b0;
                do
                    @(posedge clk);
                while (sb.pending() != 0);
            end
            steady = (i >= 200 && i < 300);

            roll = $urandom_range(0, 99);
            if (roll < 5)
                px.hue_angle = hsv_pkg::HUE_BITS'($urandom_range(92160, 131071));
            else if (roll < 12)
                px.hue_angle = hsv_pkg::HUE_BITS'($urandom_range(1, 6) * hsv_pkg::SECTOR_SPAN
                                                  - $urandom_range(0, 2));
            else
                px.hue_angle = hsv_pkg::HUE_BITS'($urandom_range(0, hsv_pkg::HUE_MAX));

            roll = $urandom_range(0, 99);
            if (roll < 10)
                px.sat_level = '0;
            else if (roll < 15)
                px.sat_level = '1;
            else
                px.sat_level = hsv_pkg::CHANNEL_BITS'($urandom);

            roll = $urandom_range(0, 99);
            if (roll < 5)
                px.bright_level = '0;
            else if (roll < 10)
                px.bright_level = '1;
            else
                px.bright_level = hsv_pkg::CHANNEL_BITS'($urandom);

            send_hsv(px);
        end
        steady = 1'b0;
        hsv_valid <= 1'b0;

        do
            @(posedge clk);
        while (sb.pending() != 0);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
